FILE: rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// Block allocation table package
// Command and status codes and the transfer payload types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

  localparam int unsigned IdFieldW      = 16;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned RemovedCountW = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_COLLECT = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_ALLOCATED = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_FREED     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_COLLECTED = 3'd4,
    STATUS_LIST      = 3'd5,
    STATUS_EMPTY     = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [IdFieldW-1:0] block_id;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [IdFieldW-1:0]      entry_id;
    logic                     entry_allocated;
    logic [RemovedCountW-1:0] removed_count;
    logic                     last;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/bat_table.sv
// ----------------------------------------------------------------------------
// Block allocation table record store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 17,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/block_allocation_table_unit.sv
// ----------------------------------------------------------------------------
// Block allocation table unit
// Ordered table of block records, newest first, with allocate, free,
// collect and list commands run by a small sequencer over one record store.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_data_i) takes one command
//   per transfer. in_stall_o is low only while the sequencer is idle, so one
//   command is worked on at a time. The output channel (out_valid_o,
//   out_stall_i, out_data_o) returns one result per transfer; list returns one
//   result per record, newest first, with last set on the final one.
//   Allocate writes its record and loads its result in state ST_ALLOC;
//   free and collect scan the store record by record (one read, one
//   check, set by the registered read port of the store); list reads
//   and gives out one entry per record. The next command is taken
//   the cycle after the last result is loaded into the output register.
//   Reset clears the record count, so the table comes up empty; the store
//   itself is not cleared. When the receiver stalls, the output register
//   holds its result and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module block_allocation_table_unit
  import bat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IdW   = (ID_BITS < IdFieldW) ? ID_BITS : IdFieldW;
  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WordW = IdW + 1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ALLOC    = 9'b000000010,
    ST_FREE_RD  = 9'b000000100,
    ST_FREE_CHK = 9'b000001000,
    ST_COL_RD   = 9'b000010000,
    ST_COL_CHK  = 9'b000100000,
    ST_LIST_RD  = 9'b001000000,
    ST_LIST_OUT = 9'b010000000,
    ST_RESP     = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic [CntW-1:0] removed_q, removed_d;
  status_e         status_q, status_d;
  logic [IdW-1:0]  id_q;

  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             out_free;
  logic             load_out;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;
  logic             rd_mark;
  logic [IdW-1:0]   rd_id;
  logic [31:0]      removed_ext;
  logic             idx_is_last;
  logic             accept;

  bat_table #(
    .Depth (TABLE_DEPTH),
    .Width (WordW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign rd_mark     = mem_rdata[IdW];
  assign rd_id       = mem_rdata[IdW-1:0];
  assign removed_ext = 32'(removed_q);
  assign idx_is_last = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    kept_d    = kept_q;
    removed_d = removed_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {1'b0, id_q};
    load_out  = 1'b0;
    out_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = IdxW'(count_q - CntW'(1));
          unique case (in_data_i.cmd)
            CMD_ALLOC: begin
              state_d = ST_ALLOC;
            end
            CMD_FREE: begin
              if (count_q == '0) begin
                status_d = STATUS_NOT_FOUND;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_FREE_RD;
              end
            end
            CMD_COLLECT: begin
              idx_d     = '0;
              kept_d    = '0;
              removed_d = '0;
              if (count_q == '0) begin
                status_d = STATUS_COLLECTED;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_COL_RD;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_LIST_RD;
              end
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_d.entry_id = IdFieldW'(id_q);
          out_d.last     = 1'b1;
          if (count_q == CntW'(TABLE_DEPTH)) begin
            out_d.status = STATUS_FULL;
          end else begin
            mem_we                = 1'b1;
            mem_waddr             = count_q[IdxW-1:0];
            mem_wdata             = {1'b1, id_q};
            count_d               = count_q + CntW'(1);
            out_d.status          = STATUS_ALLOCATED;
            out_d.entry_allocated = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_FREE_RD: begin
        state_d = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        // Scan runs from the newest record down; the first live match wins.
        if (rd_mark && (rd_id == id_q)) begin
          mem_we   = 1'b1;
          status_d = STATUS_FREED;
          state_d  = ST_RESP;
        end else if (idx_q == '0) begin
          status_d = STATUS_NOT_FOUND;
          state_d  = ST_RESP;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = ST_FREE_RD;
        end
      end
      ST_COL_RD: begin
        state_d = ST_COL_CHK;
      end
      ST_COL_CHK: begin
        // Live records are compacted toward slot zero; kept never passes idx.
        if (rd_mark) begin
          mem_we    = 1'b1;
          mem_waddr = kept_q[IdxW-1:0];
          mem_wdata = mem_rdata;
          kept_d    = kept_q + CntW'(1);
        end else begin
          removed_d = removed_q + CntW'(1);
        end
        if (idx_is_last) begin
          count_d  = kept_d;
          status_d = STATUS_COLLECTED;
          state_d  = ST_RESP;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_COL_RD;
        end
      end
      ST_LIST_RD: begin
        state_d = ST_LIST_OUT;
      end
      ST_LIST_OUT: begin
        if (out_free) begin
          load_out              = 1'b1;
          out_d.status          = STATUS_LIST;
          out_d.entry_id        = IdFieldW'(rd_id);
          out_d.entry_allocated = rd_mark;
          out_d.last            = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - IdxW'(1);
            state_d = ST_LIST_RD;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_d.status = status_q;
          out_d.last   = 1'b1;
          if (status_q == STATUS_COLLECTED) begin
            out_d.removed_count = removed_ext[RemovedCountW-1:0];
          end
          if (status_q == STATUS_FREED || status_q == STATUS_NOT_FOUND) begin
            out_d.entry_id = IdFieldW'(id_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    kept_q    <= kept_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    if (accept) begin
      id_q <= in_data_i.block_id[IdW-1:0];
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("record count exceeds table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted command did not start the sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COL_CHK) |-> (kept_q <= CntW'(idx_q)))
    else $error("collect write pointer passed the read pointer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
